/* hw/rtl/int_float_microvolt_converter_top_macros.svh */
// Assertion macros for the integer/float/microvolt converter.
// Used at the end of int_float_microvolt_converter_top; needs clk_i and rst_ni in scope.
`ifndef INT_FLOAT_MICROVOLT_CONVERTER_TOP_MACROS_SVH
`define INT_FLOAT_MICROVOLT_CONVERTER_TOP_MACROS_SVH

// Checks a property that holds in the same cycle as its condition.
`define IFMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks a property after the delay dly that follows its condition.
`define IFMC_ASSERT_DELAYED(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ifmc_pkg.sv */
// Shared types and constants for the integer/float/microvolt converter.
// No dependencies; imported by int_float_microvolt_converter_top.
`timescale 1ns / 1ps

package ifmc_pkg;

  // Conversion selected by the command field.
  typedef enum logic [1:0] {
    CmdIntToFloat = 2'd0,
    CmdFloatToInt = 2'd1,
    CmdUvToVolts  = 2'd2,
    CmdVoltsToUv  = 2'd3
  } cmd_e;

  localparam int unsigned WordW  = 32;
  localparam int unsigned MantW  = 23;
  localparam int unsigned ExpW   = 8;
  localparam int unsigned FracW  = MantW + 1;

  // Microvolts per volt; fits in 20 bits.
  localparam int unsigned UvW = 20;
  localparam logic [UvW-1:0] UvPerVolt = 20'd1000000;

  // Float-to-integer product width (24-bit significand times one million).
  localparam int unsigned ProdW = FracW + UvW;

  // Quotient of (magnitude * 2^32) / 10^6 stays below 2^44.
  localparam int unsigned QuotW = 44;

  // Exponent bases: 127 for plain integers; the volts path starts at 118
  // with the binary point 23 bits up, so its base is 118 - 23.
  localparam logic [ExpW-1:0] ExpBias     = 8'd127;
  localparam logic [ExpW-1:0] VoltExpBase = 8'd118 - 8'(MantW);

  // Reciprocal of 10^6 scaled by 2^77, rounded up. For a 32-bit magnitude N,
  // (N * UvRecip) >> 45 equals floor(N * 2^32 / 10^6) exactly.
  localparam int unsigned RecipW     = 58;
  localparam int unsigned RecipHalfW = RecipW / 2;
  localparam int unsigned RecipShift = 45;
  localparam logic [RecipW-1:0] UvRecip =
    RecipW'(((80'd1 << 77) + 80'(UvPerVolt) - 80'd1) / 80'(UvPerVolt));

  // Partial product width of the 32-bit magnitude by one half of UvRecip.
  localparam int unsigned PartW = WordW + RecipHalfW;

  // Cycles from an accepted beat to its result strobe edge.
  localparam int unsigned Latency = 5;

endpackage

/* hw/rtl/int_float_microvolt_converter_top.sv */
// Top level of the integer/float/microvolt converter: a five-register pipeline.
// Depends on ifmc_pkg and int_float_microvolt_converter_top_macros.svh.
`timescale 1ns / 1ps

// Usage
// - Input channel: drive command_i and operand_word_i with start_i high. A beat
//   is accepted at each rising edge with start_i high and busy_o low. busy_o
//   stays low, so a new beat can be given in every cycle.
// - Output channel: result_valid_o is high for exactly one cycle together with
//   result_word_o. The receiver cannot stall; results leave in input order.
// - Throughput is one conversion per cycle. An accepted beat moves in turn
//   through the input, stage 1, stage 2, stage 3 and output registers.
// - The pipeline is input register, multiply stage, add/shift stage, leading
//   one search, then normalize and output register. The latency is set by the
//   split of the 32 x 58 reciprocal multiply for the microvolt division and
//   the 44-bit normalization into separate stages.
// - Reset clears all stage valid bits, so no strobe appears from data that
//   was in flight. The data registers are not reset.
module int_float_microvolt_converter_top
  import ifmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          command_i,
  input  logic [WordW-1:0]    operand_word_i,
  output logic                result_valid_o,
  output logic [WordW-1:0]    result_word_o
);

  // Input register
  logic             in_valid_q;
  cmd_e             in_cmd_q;
  logic [WordW-1:0] in_word_q;

  // Stage 1: magnitude, products
  logic             s1_valid_q;
  cmd_e             s1_cmd_q;
  logic             s1_sign_q, s1_sign_d;
  logic             s1_zero_q, s1_zero_d;
  logic [WordW-1:0] s1_mag_q, s1_mag_d;
  logic [PartW-1:0] s1_plo_q, s1_plo_d;
  logic [PartW-1:0] s1_phi_q, s1_phi_d;
  logic [ProdW-1:0] s1_fprod_q, s1_fprod_d;
  logic [ExpW-1:0]  s1_fexp_q;
  logic [FracW-1:0] fman;

  // Stage 2: quotient, float shift
  logic             s2_valid_q;
  cmd_e             s2_cmd_q;
  logic             s2_sign_q;
  logic             s2_zero_q;
  logic [WordW-1:0] s2_mag_q;
  logic [QuotW-1:0] s2_quot_q, s2_quot_d;
  logic [WordW-1:0] s2_x_q, s2_x_d;
  logic             s2_c_q, s2_c_d;
  logic [PartW:0]   quot_sum;
  logic signed [ExpW:0] fexp_unb;
  logic [ExpW:0]    fexp_neg;
  logic [63:0]      fr64;
  logic [63:0]      fshift;

  // Stage 3: leading one, signed integer result
  logic             s3_valid_q;
  cmd_e             s3_cmd_q;
  logic             s3_sign_q;
  logic             s3_zero_q;
  logic [QuotW-1:0] s3_w_q, s3_w_d;
  logic [5:0]       s3_lead_q, s3_lead_d;
  logic [WordW-1:0] s3_ires_q, s3_ires_d;

  // Output register
  logic             out_valid_q;
  logic [WordW-1:0] out_word_q, out_word_d;
  logic [MantW-1:0] norm_mant;
  logic [ExpW-1:0]  norm_exp;

  logic accept;

  // The pipeline never stalls, so a beat is taken whenever start_i is high.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Valid chain for all stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      s1_valid_q  <= in_valid_q;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // Capture the input beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_cmd_q  <= cmd_e'(command_i);
      in_word_q <= operand_word_i;
    end
  end

  // Stage 1: take the magnitude and start both multiplications. The
  // microvolt quotient uses the reciprocal split into two halves.
  always_comb begin
    s1_sign_d = in_word_q[WordW-1];
    s1_zero_d = (in_word_q == '0);
    s1_mag_d  = s1_sign_d ? (WordW'(0) - in_word_q) : in_word_q;
    s1_plo_d  = PartW'(s1_mag_d) * PartW'(UvRecip[RecipHalfW-1:0]);
    s1_phi_d  = PartW'(s1_mag_d) * PartW'(UvRecip[RecipW-1:RecipHalfW]);
    fman      = {1'b1, in_word_q[MantW-1:0]};
    if (in_cmd_q == CmdVoltsToUv) begin
      s1_fprod_d = ProdW'(fman) * ProdW'(UvPerVolt);
    end else begin
      s1_fprod_d = ProdW'(fman);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q   <= in_cmd_q;
    s1_sign_q  <= s1_sign_d;
    s1_zero_q  <= s1_zero_d;
    s1_mag_q   <= s1_mag_d;
    s1_plo_q   <= s1_plo_d;
    s1_phi_q   <= s1_phi_d;
    s1_fprod_q <= s1_fprod_d;
    s1_fexp_q  <= in_word_q[WordW-2:MantW];
  end

  // Stage 2: finish the quotient and shift the float significand by its
  // unbiased exponent. Shifts of 64 or more in either direction give zero.
  always_comb begin
    quot_sum  = (PartW+1)'(s1_phi_q) + (PartW+1)'(s1_plo_q[PartW-1:RecipHalfW]);
    s2_quot_d = quot_sum[QuotW+RecipShift-RecipHalfW-1:RecipShift-RecipHalfW];
    fexp_unb  = $signed({1'b0, s1_fexp_q}) - $signed((ExpW+1)'(ExpBias));
    fexp_neg  = (ExpW+1)'(0) - $unsigned(fexp_unb);
    fr64      = 64'(s1_fprod_q);
    if (!fexp_unb[ExpW]) begin
      fshift = (fexp_unb[7:6] != 2'b00) ? '0 : (fr64 << fexp_unb[5:0]);
    end else begin
      fshift = (fexp_neg[7:6] != 2'b00) ? '0 : (fr64 >> fexp_neg[5:0]);
    end
    s2_x_d = fshift[54:23];
    s2_c_d = fshift[22];
  end

  always_ff @(posedge clk_i) begin
    s2_cmd_q  <= s1_cmd_q;
    s2_sign_q <= s1_sign_q;
    s2_zero_q <= s1_zero_q;
    s2_mag_q  <= s1_mag_q;
    s2_quot_q <= s2_quot_d;
    s2_x_q    <= s2_x_d;
    s2_c_q    <= s2_c_d;
  end

  // Stage 3: find the leading one of the value to normalize, and round and
  // negate the integer result in one add: -(x + c) equals ~x + !c.
  always_comb begin
    s3_w_d    = (s2_cmd_q == CmdIntToFloat) ? QuotW'(s2_mag_q) : s2_quot_q;
    s3_lead_d = '0;
    for (int i = 0; i < QuotW; i++) begin
      if (s3_w_d[i]) begin
        s3_lead_d = 6'(i);
      end
    end
    if (s2_sign_q) begin
      s3_ires_d = ~s2_x_q + WordW'(!s2_c_q);
    end else begin
      s3_ires_d = s2_x_q + WordW'(s2_c_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s3_cmd_q  <= s2_cmd_q;
    s3_sign_q <= s2_sign_q;
    s3_zero_q <= s2_zero_q;
    s3_w_q    <= s3_w_d;
    s3_lead_q <= s3_lead_d;
    s3_ires_q <= s3_ires_d;
  end

  // Stage 4: align the significand, drop the hidden bit and assemble.
  always_comb begin
    if (s3_lead_q >= 6'(MantW)) begin
      norm_mant = MantW'(s3_w_q >> (s3_lead_q - 6'(MantW)));
    end else begin
      norm_mant = MantW'(s3_w_q << (6'(MantW) - s3_lead_q));
    end
    if (s3_cmd_q == CmdIntToFloat) begin
      norm_exp = ExpBias + ExpW'(s3_lead_q);
    end else begin
      norm_exp = VoltExpBase + ExpW'(s3_lead_q);
    end
    case (s3_cmd_q)
      CmdFloatToInt, CmdVoltsToUv: begin
        out_word_d = s3_ires_q;
      end
      CmdIntToFloat, CmdUvToVolts: begin
        out_word_d = s3_zero_q ? '0 : {s3_sign_q, norm_exp, norm_mant};
      end
      default: begin
        out_word_d = s3_ires_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_word_o  = out_word_q;

  // Assertions
`include "int_float_microvolt_converter_top_macros.svh"

  `IFMC_ASSERT_DELAYED(a_latency, accept, Latency, result_valid_o, "result strobe missing after accepted beat")
  `IFMC_ASSERT_DELAYED(a_zero_int, accept && (command_i == CmdIntToFloat || command_i == CmdUvToVolts) && (operand_word_i == '0), Latency, result_word_o == '0, "zero integer did not give zero")
  `IFMC_ASSERT_DELAYED(a_int_exp, accept && (command_i == CmdIntToFloat) && (operand_word_i != '0), Latency, result_word_o[30:23] >= 8'd127 && result_word_o[30:23] <= 8'd158, "integer conversion exponent out of range")
  `IFMC_ASSERT_NOW(a_norm_nonzero, s3_valid_q && !s3_zero_q && (s3_cmd_q == CmdIntToFloat || s3_cmd_q == CmdUvToVolts), s3_w_q != '0, "nonzero operand gave zero value to normalize")

endmodule

/* tb/int_float_microvolt_converter_top_tb.sv */
// Self-checking testbench for the integer/float/microvolt converter top level.
// Depends on ifmc_pkg and int_float_microvolt_converter_top; predicts every result in-bench.
`timescale 1ns / 1ps

module int_float_microvolt_converter_top_tb
  import ifmc_pkg::*;
();

  localparam int unsigned RandomBeats  = 1150;
  localparam int unsigned IdleLimit    = 500;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned DirectedCnt  = 22;

  // Directed beats: command in the top two bits, operand below.
  localparam logic [33:0] DirectedBeats [DirectedCnt] = '{
    {CmdIntToFloat, 32'h0000_0000}, {CmdIntToFloat, 32'h0000_0001},
    {CmdIntToFloat, 32'h8000_0000}, {CmdIntToFloat, 32'h7FFF_FFFF},
    {CmdIntToFloat, 32'h01FF_FFFF},
    {CmdFloatToInt, 32'h0000_0000}, {CmdFloatToInt, 32'h3F00_0000},
    {CmdFloatToInt, 32'hBFC0_0000}, {CmdFloatToInt, 32'h7F80_0000},
    {CmdFloatToInt, 32'h5F80_0000}, {CmdFloatToInt, 32'h5F00_0000},
    {CmdFloatToInt, 32'h4F00_0000}, {CmdFloatToInt, 32'h0000_0001},
    {CmdUvToVolts,  32'h0000_0000}, {CmdUvToVolts,  32'h0000_0001},
    {CmdUvToVolts,  32'hFFFF_FFFF}, {CmdUvToVolts,  32'h8000_0000},
    {CmdUvToVolts,  32'd1000000},
    {CmdVoltsToUv,  32'h3F80_0000}, {CmdVoltsToUv,  32'hFFFF_FFFF},
    {CmdVoltsToUv,  32'h3500_0000}, {CmdVoltsToUv,  32'h4F00_0000}
  };

  typedef struct {
    cmd_e        command;
    logic [31:0] operand;
    logic [31:0] result;
  } conversion_t;

  // Holds the expected conversions in order and compares each result strobe.
  class conversion_scoreboard;
    conversion_t expected_q[$];
    int unsigned error_count;

    // Signed integer or microvolts to a single; the mantissa is truncated.
    function logic [31:0] int_to_single(logic [31:0] w, bit volts);
      logic [63:0] frac;
      logic [31:0] mag;
      int          exp_val;
      if (w == 32'd0) return 32'd0;
      mag = w[31] ? -w : w;
      if (volts) begin
        frac    = {mag, 32'd0} / 64'd1000000;
        exp_val = 118;
      end else begin
        frac    = {9'd0, mag, 23'd0};
        exp_val = 127;
      end
      while (frac[63:24] != 40'd0) begin
        frac = frac >> 1;
        exp_val++;
      end
      while (!frac[23]) begin
        frac = frac << 1;
        exp_val--;
      end
      return {w[31], 8'(exp_val), frac[22:0]};
    endfunction

    // Single (or volts) to a signed integer (or microvolts), rounding half away from zero.
    // Exponent codes 0 and 255 carry no special meaning here.
    function logic [31:0] single_to_int(logic [31:0] w, bit volts);
      logic [63:0] frac;
      logic [31:0] res;
      int          shamt;
      frac  = {40'd0, 1'b1, w[22:0]};
      shamt = int'(w[30:23]) - 127;
      if (volts) frac = frac * 64'd1000000;
      if (shamt >= 64 || shamt <= -64) frac = 64'd0;
      else if (shamt > 0) frac = frac << shamt;
      else if (shamt < 0) frac = frac >> (-shamt);
      if (frac[22]) frac = (frac >> 23) + 64'd1;
      else          frac = frac >> 23;
      res = frac[31:0];
      if (w[31]) res = -res;
      return res;
    endfunction

    function logic [31:0] convert_word(cmd_e c, logic [31:0] w);
      case (c)
        CmdIntToFloat: return int_to_single(w, 1'b0);
        CmdFloatToInt: return single_to_int(w, 1'b0);
        CmdUvToVolts:  return int_to_single(w, 1'b1);
        default:       return single_to_int(w, 1'b1);
      endcase
    endfunction

    function void note_beat(cmd_e c, logic [31:0] w);
      conversion_t item;
      item.command = c;
      item.operand = w;
      item.result  = convert_word(c, w);
      expected_q.push_back(item);
    endfunction

    function void check_result(logic [31:0] got);
      conversion_t item;
      if (expected_q.size() == 0) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("Unexpected result beat %08h with nothing pending", got);
        return;
      end
      item = expected_q.pop_front();
      if (got !== item.result) begin
        error_count++;
        if (error_count <= ReportLimit)
          $display("Mismatch: command %s operand %08h expected %08h got %08h",
                   item.command.name(), item.operand, item.result, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = CmdIntToFloat;
  logic [31:0] operand_word_i = 32'd0;
  logic        result_valid_o;
  logic [31:0] result_word_o;

  conversion_scoreboard sb = new();
  int unsigned idle_cycles;
  int unsigned burst_left;

  int_float_microvolt_converter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .operand_word_i (operand_word_i),
    .result_valid_o (result_valid_o),
    .result_word_o  (result_word_o)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 0;
  end

  // Monitor: record accepted beats, check result strobes, and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_beat(cmd_e'(command_i), operand_word_i);
      if (result_valid_o) sb.check_result(result_word_o);
      if ((start_i && !busy_o) || result_valid_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Gap before the next beat: mostly none, some short, a few long, with bursts of none.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random operand: raw words, small integers, floats around the useful range
  // and at exponent codes 0, 126, 127 and 255, and wide integers of either sign.
  function automatic logic [31:0] pick_operand();
    logic [31:0] w;
    int          small_val;
    case ($urandom_range(0, 9))
      0, 1, 2: w = $urandom;
      3, 4: begin
        small_val = int'($urandom_range(0, 4000)) - 2000;
        w = small_val;
      end
      5, 6, 7: w = {1'($urandom), 8'($urandom_range(100, 195)), 23'($urandom)};
      8: begin
        case ($urandom_range(0, 3))
          0:       w = {1'($urandom), 8'd0, 23'($urandom)};
          1:       w = {1'($urandom), 8'd255, 23'($urandom)};
          2:       w = {1'($urandom), 8'd126, 23'($urandom)};
          default: w = {1'($urandom), 8'd127, 23'($urandom)};
        endcase
      end
      default: begin
        w = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) w = -w;
      end
    endcase
    return w;
  endfunction

  // Present one beat and hold it until the block takes it.
  task automatic send_beat(cmd_e c, logic [31:0] w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i      <= c;
    operand_word_i <= w;
    start_i        <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Stimulus: reset, directed corner cases, random traffic, then drain.
  initial begin
    idle_cycles = 0;
    burst_left  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedCnt; i++)
      send_beat(cmd_e'(DirectedBeats[i][33:32]), DirectedBeats[i][31:0]);

    for (int i = 0; i < RandomBeats; i++)
      send_beat(cmd_e'($urandom_range(0, 3)), pick_operand());

    start_i <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (Latency + 3) @(posedge clk_i);

    if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ifmc_pkg.sv
hw/rtl/int_float_microvolt_converter_top.sv
tb/int_float_microvolt_converter_top_tb.sv
